// ===== hw/rtl/pacp_pkg.sv =====
package pacp_pkg;

  localparam int MaxVertices = 64;
  localparam int MinVertices = 3;
  localparam int AddrW       = $clog2(MaxVertices);
  localparam int CntW        = $clog2(MaxVertices + 1);
  localparam int CoordW      = 32;
  localparam int SumW        = CoordW + CntW;
  localparam int DiffW       = CoordW + 1;
  localparam int MulW        = DiffW + 1;
  localparam int ProdW       = 2 * MulW;
  localparam int CrossW      = 2 * DiffW;
  localparam int AccW        = 2 * CrossW + 2;
  localparam int AreaShift   = 34;
  localparam int RadW        = AccW - AreaShift - 2;
  localparam int RootW       = RadW / 2;
  localparam int RemW        = RootW + 3;
  localparam int SqCntW      = $clog2(RootW + 1);
  localparam int DivCntW     = $clog2(SumW + 1);
  localparam int PerimW      = 48;
  localparam int AreaW       = 64;
  localparam int VcountW     = 7;
  localparam int FifoDepth   = 2;

  localparam logic [PerimW-1:0] PerimMax  = '1;
  localparam logic [AreaW-1:0]  AreaMax   = '1;
  localparam logic [2:0]        PStepLast = 3'd3;
  localparam logic [2:0]        AStepLast = 3'd6;

  typedef logic [0:2][CoordW-1:0] vtx_t;

  typedef struct packed {
    logic signed [CoordW-1:0] vertex_x;
    logic signed [CoordW-1:0] vertex_y;
    logic signed [CoordW-1:0] vertex_z;
    logic                     last_vertex;
  } vtx_in_t;

  typedef struct packed {
    logic signed [CoordW-1:0] center_x;
    logic signed [CoordW-1:0] center_y;
    logic signed [CoordW-1:0] center_z;
    logic [PerimW-1:0]        perimeter;
    logic [AreaW-1:0]         area;
    logic [VcountW-1:0]       vertex_count;
    logic                     overflow;
  } poly_out_t;

  typedef struct packed {
    logic [CntW-1:0] n;
    logic            ovf;
  } job_t;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] addr;
    vtx_t             data;
  } ram_wr_t;

  typedef enum logic [3:0] {
    BK_IDLE, BK_SUM, BK_DIV, BK_PRD, BK_PLD, BK_PMUL, BK_PST, BK_PSQ,
    BK_ARD0, BK_ALD0, BK_ARD, BK_ALD, BK_AMUL, BK_AST, BK_ASQ, BK_OUT
  } back_state_e;

endpackage

// ===== hw/rtl/polygon_area_centroid_perimeter_core.sv =====
// polygon centroid, perimeter and fan area, 3d, signed q16.16 vertices
//
// input channel: one vertex word per accepted beat (in_valid_i high, in_stall_o
// low); last_vertex closes the polygon. vertices load at one per cycle, while
// not stalled, into a 64-entry store; extras are dropped and set overflow.
// after the closing vertex the back end walks the store: it sums the vertices,
// runs three rounded divisions for the centroid, then works through each edge
// and each fan triangle on the shared 49-step square root unit and the single
// 34x34 multiplier. under three vertices the back end goes straight to the
// zero result. in_stall_o stays high while a polygon is being worked on.
// output channel: one result word per polygon, held in an output register
// while out_stall_i is high; the back end waits on a full register.
// reset (rst_ni low, asynchronous) empties the job queue, drops any partial
// polygon and clears the output valid; the vertex store needs no clearing.
module polygon_area_centroid_perimeter_core import pacp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  vtx_in_t   in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output poly_out_t out_word_o
);

  ram_wr_t          ram_wr;
  logic             job_valid, job_pop, back_busy;
  job_t             job;
  logic [AddrW-1:0] rd_addr;
  vtx_t             rd_data;
  logic             sq_start, sq_done;
  logic [RadW-1:0]  sq_rad;
  logic [RootW-1:0] sq_root;

  pacp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .back_busy_i (back_busy),
    .ram_wr_o    (ram_wr),
    .job_valid_o (job_valid),
    .job_o       (job),
    .job_pop_i   (job_pop)
  );

  pacp_ram #(
    .Width ($bits(vtx_t)),
    .Depth (MaxVertices)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_wr.we),
    .waddr_i (ram_wr.addr),
    .wdata_i (ram_wr.data),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  pacp_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .rad_i   (sq_rad),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  pacp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job),
    .job_pop_o   (job_pop),
    .busy_o      (back_busy),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .sq_start_o  (sq_start),
    .sq_rad_o    (sq_rad),
    .sq_done_i   (sq_done),
    .sq_root_i   (sq_root),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

// ===== hw/rtl/pacp_ram.sv =====
module pacp_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== hw/rtl/pacp_front.sv =====
module pacp_front import pacp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  vtx_in_t in_word_i,
  input  logic    back_busy_i,
  output ram_wr_t ram_wr_o,
  output logic    job_valid_o,
  output job_t    job_o,
  input  logic    job_pop_i
);

  logic [CntW-1:0] vcnt_q;
  logic            ovf_q;
  job_t            fq_q [FifoDepth];
  logic            wp_q, rp_q;
  logic [1:0]      fcnt_q;
  logic            accept, full, push;
  job_t            job_new;

  // hold off the next polygon while the store is being walked
  assign in_stall_o  = (fcnt_q != 2'd0) || back_busy_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign full        = vcnt_q == CntW'(MaxVertices);
  assign push        = accept && in_word_i.last_vertex;
  assign job_new.n   = full ? vcnt_q : CntW'(vcnt_q + 1'b1);
  assign job_new.ovf = ovf_q || full;

  assign ram_wr_o.we   = accept && !full;
  assign ram_wr_o.addr = vcnt_q[AddrW-1:0];
  assign ram_wr_o.data = {in_word_i.vertex_x, in_word_i.vertex_y, in_word_i.vertex_z};

  assign job_valid_o = fcnt_q != 2'd0;
  assign job_o       = fq_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcnt_q <= '0;
      ovf_q  <= 1'b0;
      wp_q   <= 1'b0;
      rp_q   <= 1'b0;
      fcnt_q <= '0;
    end else begin
      if (accept) begin
        if (in_word_i.last_vertex) begin
          vcnt_q <= '0;
          ovf_q  <= 1'b0;
        end else if (full) begin
          ovf_q <= 1'b1;
        end else begin
          vcnt_q <= CntW'(vcnt_q + 1'b1);
        end
      end
      if (push) begin
        wp_q <= ~wp_q;
      end
      if (job_pop_i) begin
        rp_q <= ~rp_q;
      end
      if (push && !job_pop_i) begin
        fcnt_q <= fcnt_q + 2'd1;
      end else if (!push && job_pop_i) begin
        fcnt_q <= fcnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fq_q[wp_q] <= job_new;
    end
  end

endmodule

// ===== hw/rtl/pacp_sqrt.sv =====
module pacp_sqrt import pacp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [RadW-1:0]  rad_i,
  output logic             done_o,
  output logic [RootW-1:0] root_o
);

  logic              busy_q;
  logic [SqCntW-1:0] cnt_q;
  logic [RadW-1:0]   rad_q;
  logic [RemW-1:0]   rem_q, rem_sh, trial;
  logic [RootW-1:0]  root_q;
  logic              ge;

  // one result bit per cycle, two radicand bits shifted in
  assign rem_sh = {rem_q[RemW-3:0], rad_q[RadW-1 -: 2]};
  assign trial  = RemW'({root_q, 2'b01});
  assign ge     = rem_sh >= trial;
  assign done_o = busy_q && (cnt_q == '0);
  assign root_o = root_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= SqCntW'(RootW);
    end else if (busy_q) begin
      if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
      end else begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q && (cnt_q != '0)) begin
      rad_q  <= rad_q << 2;
      rem_q  <= ge ? rem_sh - trial : rem_sh;
      root_q <= {root_q[RootW-2:0], ge};
    end
  end

endmodule

// ===== hw/rtl/pacp_back.sv =====
module pacp_back import pacp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             job_valid_i,
  input  job_t             job_i,
  output logic             job_pop_o,
  output logic             busy_o,
  output logic [AddrW-1:0] rd_addr_o,
  input  vtx_t             rd_data_i,
  output logic             sq_start_o,
  output logic [RadW-1:0]  sq_rad_o,
  input  logic             sq_done_i,
  input  logic [RootW-1:0] sq_root_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output poly_out_t        out_word_o
);

  back_state_e state_q, state_d;

  logic [CntW-1:0]    idx_q, n_q;
  logic [1:0]         k_q, ld_k, u_k, w_k;
  logic [2:0]         mstep_q;
  logic [DivCntW-1:0] dcnt_q;
  logic               rv_q, rd_issue, oval_q, oload, ovf_q;

  logic signed [SumW-1:0]   sum_q [3];
  logic [CoordW-1:0]        cen_q [3];
  logic signed [DiffW-1:0]  dd_q [3];
  logic signed [DiffW-1:0]  ad_q [3];
  logic signed [DiffW-1:0]  bd_q [3];
  vtx_t                     o_q, prev_q, cur_q, pa_q;

  logic signed [MulW-1:0]   mul_a, mul_b;
  logic signed [ProdW-1:0]  product, prod_q, t_q, xd, xa;
  logic [CrossW-1:0]        c_q;
  logic [AccW-1:0]          acc_q, prod_ext;
  logic [PerimW-1:0]        perim_q;
  logic [PerimW+1:0]        psum;
  logic [AreaW-1:0]         area_q;
  logic [AreaW:0]           asum;

  logic [SumW-1:0]          dvd_q, quo_q, ld_dvd;
  logic signed [SumW-1:0]   ld_sum, ld_mag;
  logic [CntW-1:0]          rem_q;
  logic [CntW:0]            dv_rem;
  logic                     dv_ge, neg_q;
  logic [CoordW-1:0]        q32;
  poly_out_t                res, oword_q;

  // ---------------- next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: if (job_valid_i) begin
        state_d = (job_i.n >= CntW'(MinVertices)) ? BK_SUM : BK_OUT;
      end
      BK_SUM:  if (idx_q == n_q && !rv_q) state_d = BK_DIV;
      BK_DIV:  if (dcnt_q == '0 && k_q == 2'd2) state_d = BK_PRD;
      BK_PRD:  state_d = BK_PLD;
      BK_PLD:  state_d = BK_PMUL;
      BK_PMUL: if (mstep_q == PStepLast) state_d = BK_PST;
      BK_PST:  state_d = BK_PSQ;
      BK_PSQ:  if (sq_done_i) begin
        state_d = (CntW'(idx_q + 1'b1) == n_q) ? BK_ARD0 : BK_PRD;
      end
      BK_ARD0: state_d = BK_ALD0;
      BK_ALD0: state_d = BK_ARD;
      BK_ARD:  state_d = BK_ALD;
      BK_ALD:  state_d = BK_AMUL;
      BK_AMUL: if (mstep_q == AStepLast && k_q == 2'd2) state_d = BK_AST;
      BK_AST:  state_d = BK_ASQ;
      BK_ASQ:  if (sq_done_i) begin
        state_d = (({1'b0, idx_q} + (CntW+1)'(MinVertices)) == {1'b0, n_q}) ? BK_OUT : BK_ARD;
      end
      BK_OUT:  if (!oval_q || !out_stall_i) state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  // ---------------- outputs
  always_comb begin
    job_pop_o  = (state_q == BK_IDLE) && job_valid_i;
    busy_o     = state_q != BK_IDLE;
    rd_issue   = (state_q == BK_SUM) && (idx_q < n_q);
    sq_start_o = (state_q == BK_PST) || (state_q == BK_AST);
    sq_rad_o   = (state_q == BK_AST) ? acc_q[RadW+AreaShift-1:AreaShift] : acc_q[RadW-1:0];
    oload      = (state_q == BK_OUT) && (!oval_q || !out_stall_i);
    case (state_q)
      BK_SUM, BK_PRD: rd_addr_o = idx_q[AddrW-1:0];
      BK_ARD:         rd_addr_o = AddrW'(idx_q + 1'b1);
      default:        rd_addr_o = '0;
    endcase
  end

  // ---------------- shared multiplier operand select
  always_comb begin
    case (k_q)
      2'd0:    begin u_k = 2'd1; w_k = 2'd2; end
      2'd1:    begin u_k = 2'd2; w_k = 2'd0; end
      default: begin u_k = 2'd0; w_k = 2'd1; end
    endcase
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      BK_PMUL: if (mstep_q < PStepLast) begin
        mul_a = MulW'(dd_q[mstep_q[1:0]]);
        mul_b = MulW'(dd_q[mstep_q[1:0]]);
      end
      BK_AMUL: begin
        case (mstep_q)
          3'd0: begin mul_a = MulW'(ad_q[u_k]); mul_b = MulW'(bd_q[w_k]); end
          3'd1: begin mul_a = MulW'(ad_q[w_k]); mul_b = MulW'(bd_q[u_k]); end
          3'd3: begin
            mul_a = {1'b0, c_q[CrossW-1:DiffW]};
            mul_b = {1'b0, c_q[CrossW-1:DiffW]};
          end
          3'd4: begin
            mul_a = {1'b0, c_q[CrossW-1:DiffW]};
            mul_b = {1'b0, c_q[DiffW-1:0]};
          end
          3'd5: begin
            mul_a = {1'b0, c_q[DiffW-1:0]};
            mul_b = {1'b0, c_q[DiffW-1:0]};
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign product  = mul_a * mul_b;
  assign prod_ext = AccW'($unsigned(prod_q));
  assign xd       = t_q - prod_q;
  assign xa       = xd[ProdW-1] ? -xd : xd;
  assign psum     = (PerimW+2)'(perim_q) + (PerimW+2)'(sq_root_i);
  assign asum     = (AreaW+1)'(area_q) + (AreaW+1)'(sq_root_i);

  // rounded mean: (|sum| + n/2) / n, one quotient bit per cycle
  assign ld_k   = (state_q == BK_SUM) ? 2'd0 : ((k_q == 2'd2) ? 2'd2 : k_q + 2'd1);
  assign ld_sum = sum_q[ld_k];
  assign ld_mag = ld_sum[SumW-1] ? -ld_sum : ld_sum;
  assign ld_dvd = ld_mag + SumW'(n_q >> 1);
  assign dv_rem = {rem_q, dvd_q[SumW-1]};
  assign dv_ge  = dv_rem >= {1'b0, n_q};
  assign q32    = quo_q[CoordW-1:0];

  always_comb begin
    res.center_x     = cen_q[0];
    res.center_y     = cen_q[1];
    res.center_z     = cen_q[2];
    res.perimeter    = perim_q;
    res.area         = area_q;
    res.vertex_count = VcountW'(n_q);
    res.overflow     = ovf_q;
  end

  assign out_valid_o = oval_q;
  assign out_word_o  = oword_q;

  // ---------------- control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      idx_q   <= '0;
      k_q     <= '0;
      mstep_q <= '0;
      dcnt_q  <= '0;
      rv_q    <= 1'b0;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      rv_q    <= rd_issue;
      if (oload) begin
        oval_q <= 1'b1;
      end else if (!out_stall_i) begin
        oval_q <= 1'b0;
      end
      case (state_q)
        BK_IDLE: begin
          idx_q <= '0;
          k_q   <= '0;
        end
        BK_SUM: begin
          if (rd_issue) idx_q <= CntW'(idx_q + 1'b1);
          if (state_d == BK_DIV) begin
            dcnt_q <= DivCntW'(SumW);
            k_q    <= '0;
          end
        end
        BK_DIV: begin
          if (dcnt_q != '0) begin
            dcnt_q <= dcnt_q - 1'b1;
          end else begin
            k_q    <= k_q + 2'd1;
            dcnt_q <= DivCntW'(SumW);
            idx_q  <= '0;
          end
        end
        BK_PLD, BK_ALD: begin
          mstep_q <= '0;
          k_q     <= '0;
        end
        BK_PMUL: mstep_q <= mstep_q + 3'd1;
        BK_AMUL: begin
          if (mstep_q == AStepLast) begin
            mstep_q <= '0;
            k_q     <= k_q + 2'd1;
          end else begin
            mstep_q <= mstep_q + 3'd1;
          end
        end
        BK_PSQ: if (sq_done_i) begin
          idx_q <= (state_d == BK_ARD0) ? '0 : CntW'(idx_q + 1'b1);
        end
        BK_ASQ: if (sq_done_i) idx_q <= CntW'(idx_q + 1'b1);
        default: ;
      endcase
    end
  end

  // ---------------- datapath
  always_ff @(posedge clk_i) begin
    if (oload) begin
      oword_q <= res;
    end
    case (state_q)
      BK_IDLE: if (job_valid_i) begin
        n_q     <= job_i.n;
        ovf_q   <= job_i.ovf;
        perim_q <= '0;
        area_q  <= '0;
        for (int c = 0; c < 3; c++) begin
          sum_q[c] <= '0;
          cen_q[c] <= '0;
        end
      end
      BK_SUM: begin
        if (rv_q) begin
          for (int c = 0; c < 3; c++) begin
            sum_q[c] <= sum_q[c] + SumW'($signed(rd_data_i[c]));
          end
          o_q <= rd_data_i;
        end
        if (state_d == BK_DIV) begin
          dvd_q <= ld_dvd;
          rem_q <= '0;
          quo_q <= '0;
          neg_q <= ld_sum[SumW-1];
        end
      end
      BK_DIV: begin
        if (dcnt_q != '0) begin
          dvd_q <= dvd_q << 1;
          rem_q <= CntW'(dv_ge ? dv_rem - {1'b0, n_q} : dv_rem);
          quo_q <= {quo_q[SumW-2:0], dv_ge};
        end else begin
          cen_q[k_q] <= neg_q ? -q32 : q32;
          dvd_q      <= ld_dvd;
          rem_q      <= '0;
          quo_q      <= '0;
          neg_q      <= ld_sum[SumW-1];
          prev_q     <= o_q;
        end
      end
      BK_PLD: begin
        cur_q <= rd_data_i;
        for (int c = 0; c < 3; c++) begin
          dd_q[c] <= DiffW'($signed(rd_data_i[c])) - DiffW'($signed(prev_q[c]));
        end
      end
      BK_PMUL: begin
        case (mstep_q)
          3'd0: begin
            prod_q <= product;
            acc_q  <= '0;
          end
          3'd1, 3'd2: begin
            acc_q  <= acc_q + prod_ext;
            prod_q <= product;
          end
          default: acc_q <= acc_q + prod_ext;
        endcase
      end
      BK_PSQ: if (sq_done_i) begin
        perim_q <= (|psum[PerimW+1:PerimW]) ? PerimMax : psum[PerimW-1:0];
        prev_q  <= cur_q;
      end
      BK_ALD0: pa_q <= rd_data_i;
      BK_ALD: begin
        cur_q <= rd_data_i;
        acc_q <= '0;
        for (int c = 0; c < 3; c++) begin
          ad_q[c] <= DiffW'($signed(pa_q[c])) - DiffW'($signed(o_q[c]));
          bd_q[c] <= DiffW'($signed(rd_data_i[c])) - DiffW'($signed(o_q[c]));
        end
      end
      BK_AMUL: begin
        // cross component, then its square from hi/lo halves
        case (mstep_q)
          3'd0: prod_q <= product;
          3'd1: begin
            t_q    <= prod_q;
            prod_q <= product;
          end
          3'd2: c_q <= xa[CrossW-1:0];
          3'd3: prod_q <= product;
          3'd4: begin
            acc_q  <= acc_q + (prod_ext << CrossW);
            prod_q <= product;
          end
          3'd5: begin
            acc_q  <= acc_q + (prod_ext << (DiffW + 1));
            prod_q <= product;
          end
          default: acc_q <= acc_q + prod_ext;
        endcase
      end
      BK_ASQ: if (sq_done_i) begin
        area_q <= asum[AreaW] ? AreaMax : asum[AreaW-1:0];
        pa_q   <= cur_q;
      end
      default: ;
    endcase
  end

endmodule
